// ----- hw/rtl/pva_pkg.sv -----
// Shared types and codes for the polyphonic voice allocator.
// No dependencies.
package pva_pkg;

   localparam int NUM_VOICES_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam logic [5:0] LIMIT_RESET = 6'd10;
   localparam logic [6:0] PEDAL_HOLD  = 7'h40;

   localparam logic [2:0] FUNC_NOTE_ON  = 3'd0;
   localparam logic [2:0] FUNC_NOTE_OFF = 3'd1;
   localparam logic [2:0] FUNC_PEDAL    = 3'd2;
   localparam logic [2:0] FUNC_TICK     = 3'd3;
   localparam logic [2:0] FUNC_FINISHED = 3'd4;
   localparam logic [2:0] FUNC_CLEAR    = 3'd5;

   localparam logic [2:0] EV_DONE    = 3'd0;
   localparam logic [2:0] EV_ALLOC   = 3'd1;
   localparam logic [2:0] EV_GATE    = 3'd2;
   localparam logic [2:0] EV_RETIRED = 3'd3;
   localparam logic [2:0] EV_FULL    = 3'd4;

   localparam logic [1:0] GATE_OFF   = 2'd0;
   localparam logic [1:0] GATE_ON    = 2'd1;
   localparam logic [1:0] GATE_PEDAL = 2'd2;

   typedef enum logic [2:0] {
      OP_NOTE_ON, OP_NOTE_OFF, OP_PEDAL, OP_TICK, OP_FINISHED, OP_CLEAR, OP_NOP
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] note_key;
      logic [6:0] pedal_value;
      logic [4:0] voice_slot;
   } cmd_type;

   typedef struct packed {
      logic [2:0] ev;
      logic [4:0] slot;
      logic [6:0] key;
      logic [1:0] gate;
   } res_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCAN_ON, ST_EXEC_ON, ST_ON_ALLOC, ST_SCAN_OFF,
      ST_DEC_CHK, ST_DEC_SCAN, ST_HELD_CHK, ST_HELD_SCAN, ST_RETIRE,
      ST_GATE, ST_RETIRE_ONE, ST_CLEAR, ST_FINISH, ST_DRAIN_RD, ST_DRAIN_LD
   } state_type;

endpackage

// ----- hw/rtl/pva_front.sv -----
// Front end: accepts request transactions, classifies them and queues commands.
// Depends on pva_pkg.
module pva_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output pva_pkg::cmd_type cmd
);
   import pva_pkg::*;

   cmd_type    q_ff [QUEUE_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    dec;

   always_comb begin
      case (req_tdata[2:0])
         FUNC_NOTE_ON:  dec.op = OP_NOTE_ON;
         FUNC_NOTE_OFF: dec.op = OP_NOTE_OFF;
         FUNC_PEDAL:    dec.op = OP_PEDAL;
         FUNC_TICK:     dec.op = OP_TICK;
         FUNC_FINISHED: dec.op = OP_FINISHED;
         FUNC_CLEAR:    dec.op = OP_CLEAR;
         default:       dec.op = OP_NOP;
      endcase
      dec.note_key    = req_tdata[9:3];
      dec.pedal_value = req_tdata[16:10];
      dec.voice_slot  = req_tdata[21:17];
   end

   assign req_tready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[0];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         q_ff[0] <= (push && cnt_ff == 2'd1) ? dec : q_ff[1];
         if (push && cnt_ff == 2'd2) begin
            q_ff[1] <= dec;
         end
      end else if (push) begin
         q_ff[cnt_ff[0]] <= dec;
      end
   end

endmodule

// ----- hw/rtl/pva_engine.sv -----
// Back end: voice table, sequencer, result buffer and response register.
// Depends on pva_pkg.
module pva_engine #(
   parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [5:0]       voice_limit,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  pva_pkg::cmd_type cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import pva_pkg::*;

   localparam int SW = $clog2(NUM_VOICES);
   localparam int CW = $clog2(NUM_VOICES + 1);
   localparam int RD = NUM_VOICES + 2;
   localparam int AW = $clog2(RD);
   localparam int WW = $clog2(RD + 1);

   state_type state_ff, state_in;
   logic [NUM_VOICES-1:0] valid_ff, valid_in, decay_ff, decay_in;
   logic [1:0]  gate_ff  [NUM_VOICES];
   logic [1:0]  gate_in  [NUM_VOICES];
   logic [6:0]  key_ff   [NUM_VOICES];
   logic [6:0]  key_in   [NUM_VOICES];
   logic [15:0] stamp_ff [NUM_VOICES];
   logic [15:0] stamp_in [NUM_VOICES];

   cmd_type     cmd_ff, cmd_in;
   logic [SW-1:0] idx_ff, idx_in, fr_ff, fr_in, old_ff, old_in, best_ff, best_in;
   logic        frf_ff, frf_in, oldf_ff, oldf_in, bestf_ff, bestf_in;
   logic        bdec_ff, bdec_in;
   logic [15:0] bage_ff, bage_in, ctr_ff, ctr_in;
   logic [6:0]  bkey_ff, bkey_in, ped_ff, ped_in;
   logic [CW-1:0] held_ff, held_in, dcnt_ff, dcnt_in;
   logic [WW-1:0] wcnt_ff, wcnt_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   res_type     mem [RD];
   res_type     rdata_ff, wr_data;
   logic        wr_en;
   res_type     out_ff, out_in;
   logic [5:0]  oheld_ff, oheld_in, odec_ff, odec_in;
   logic        ovalid_ff, ovalid_in, olast_ff, olast_in;

   logic        last_idx, cur_valid, cur_dec, key_hit, take_best, over, out_free;
   logic [15:0] age;
   logic [7:0]  tot;
   logic [1:0]  cur_gate;

   assign last_idx  = (idx_ff == SW'(NUM_VOICES - 1));
   assign cur_valid = valid_ff[idx_ff];
   assign cur_dec   = decay_ff[idx_ff];
   assign cur_gate  = gate_ff[idx_ff];
   assign key_hit   = cur_valid & ~cur_dec & (key_ff[idx_ff] == cmd_ff.note_key);
   assign age       = ctr_ff - stamp_ff[idx_ff];
   assign tot       = 8'(held_ff) + 8'(dcnt_ff);
   assign over      = tot > 8'(voice_limit);
   assign out_free  = ~ovalid_ff | rsp_tready;
   assign take_best = cur_valid & (cur_dec == (state_ff == ST_DEC_SCAN)) &
                      (~bestf_ff | ((state_ff == ST_DEC_SCAN) ? (age < bage_ff)
                                                              : (age > bage_ff)));
   assign cmd_pop   = (state_ff == ST_IDLE) & cmd_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_NOTE_ON:  state_in = ST_SCAN_ON;
                  OP_NOTE_OFF: state_in = ST_SCAN_OFF;
                  OP_TICK:     state_in = (voice_limit != 6'd0 && over) ? ST_DEC_CHK
                                                                        : ST_GATE;
                  OP_FINISHED: state_in = ST_RETIRE_ONE;
                  OP_CLEAR:    state_in = ST_CLEAR;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN_ON:    if (last_idx) state_in = ST_EXEC_ON;
         ST_EXEC_ON:    state_in = frf_ff ? ST_ON_ALLOC : ST_FINISH;
         ST_ON_ALLOC:   state_in = ST_FINISH;
         ST_SCAN_OFF:   if (key_hit || last_idx) state_in = ST_FINISH;
         ST_DEC_CHK:    state_in = (dcnt_ff != '0 && over) ? ST_DEC_SCAN : ST_HELD_CHK;
         ST_DEC_SCAN:   if (last_idx) state_in = (bestf_ff | take_best) ? ST_RETIRE
                                                                        : ST_HELD_CHK;
         ST_HELD_CHK:   state_in = (8'(held_ff) > 8'(voice_limit)) ? ST_HELD_SCAN
                                                                   : ST_GATE;
         ST_HELD_SCAN:  if (last_idx) state_in = (bestf_ff | take_best) ? ST_RETIRE
                                                                        : ST_GATE;
         ST_RETIRE:     state_in = bdec_ff ? ST_DEC_CHK : ST_HELD_CHK;
         ST_GATE:       if (ped_ff >= PEDAL_HOLD || last_idx) state_in = ST_FINISH;
         ST_RETIRE_ONE: state_in = ST_FINISH;
         ST_CLEAR:      if (last_idx) state_in = ST_FINISH;
         ST_FINISH:     state_in = ST_DRAIN_RD;
         ST_DRAIN_RD:   state_in = ST_DRAIN_LD;
         ST_DRAIN_LD: begin
            if (out_free) begin
               state_in = (WW'(rptr_ff) + 1'b1 == wcnt_ff) ? ST_IDLE : ST_DRAIN_RD;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      valid_in = valid_ff;
      decay_in = decay_ff;
      gate_in  = gate_ff;
      key_in   = key_ff;
      stamp_in = stamp_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      fr_in    = fr_ff;
      frf_in   = frf_ff;
      old_in   = old_ff;
      oldf_in  = oldf_ff;
      best_in  = best_ff;
      bestf_in = bestf_ff;
      bage_in  = bage_ff;
      bkey_in  = bkey_ff;
      bdec_in  = bdec_ff;
      ctr_in   = ctr_ff;
      ped_in   = ped_ff;
      held_in  = held_ff;
      dcnt_in  = dcnt_ff;
      wcnt_in  = wcnt_ff;
      rptr_in  = rptr_ff;
      out_in   = out_ff;
      oheld_in = oheld_ff;
      odec_in  = odec_ff;
      olast_in = olast_ff;
      ovalid_in = ovalid_ff & ~rsp_tready;
      wr_en    = 1'b0;
      wr_data  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in  = cmd;
               idx_in  = '0;
               frf_in  = 1'b0;
               oldf_in = 1'b0;
               if (cmd.op == OP_PEDAL) ped_in = cmd.pedal_value;
               if (cmd.op == OP_FINISHED) idx_in = SW'(32'(cmd.voice_slot));
            end
         end
         ST_SCAN_ON: begin
            if (!cur_valid && !frf_ff) begin
               frf_in = 1'b1;
               fr_in  = idx_ff;
            end
            if (key_hit && !oldf_ff) begin
               oldf_in = 1'b1;
               old_in  = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         ST_EXEC_ON: begin
            wr_en = 1'b1;
            if (!frf_ff) begin
               wr_data = '{EV_FULL, 5'd0, cmd_ff.note_key, GATE_OFF};
            end else if (oldf_ff) begin
               decay_in[old_ff] = 1'b1;
               gate_in[old_ff]  = GATE_OFF;
               stamp_in[old_ff] = ctr_ff;
               ctr_in  = ctr_ff + 16'd1;
               if (held_ff != '0) held_in = held_ff - 1'b1;
               dcnt_in = dcnt_ff + 1'b1;
               wr_data = '{EV_GATE, 5'(old_ff), cmd_ff.note_key, GATE_OFF};
            end else begin
               wr_en = 1'b0;
            end
         end
         ST_ON_ALLOC: begin
            valid_in[fr_ff] = 1'b1;
            decay_in[fr_ff] = 1'b0;
            key_in[fr_ff]   = cmd_ff.note_key;
            gate_in[fr_ff]  = GATE_ON;
            stamp_in[fr_ff] = oldf_ff ? ctr_ff : ctr_ff;
            ctr_in  = ctr_ff + 16'd1;
            held_in = held_ff + 1'b1;
            wr_en   = 1'b1;
            wr_data = '{EV_ALLOC, 5'(fr_ff), cmd_ff.note_key, GATE_ON};
         end
         ST_SCAN_OFF: begin
            if (key_hit) begin
               gate_in[idx_ff] = (ped_ff != 7'd0) ? GATE_PEDAL : GATE_OFF;
               wr_en   = 1'b1;
               wr_data = '{EV_GATE, 5'(idx_ff), cmd_ff.note_key,
                           (ped_ff != 7'd0) ? GATE_PEDAL : GATE_OFF};
            end
            idx_in = idx_ff + 1'b1;
         end
         ST_DEC_CHK, ST_HELD_CHK: begin
            idx_in   = '0;
            bestf_in = 1'b0;
         end
         ST_DEC_SCAN, ST_HELD_SCAN: begin
            if (take_best) begin
               bestf_in = 1'b1;
               best_in  = idx_ff;
               bage_in  = age;
               bkey_in  = key_ff[idx_ff];
               bdec_in  = cur_dec;
            end
            idx_in = last_idx ? '0 : idx_ff + 1'b1;
         end
         ST_RETIRE: begin
            if (bdec_ff) begin
               if (dcnt_ff != '0) dcnt_in = dcnt_ff - 1'b1;
            end else if (held_ff != '0) begin
               held_in = held_ff - 1'b1;
            end
            valid_in[best_ff] = 1'b0;
            decay_in[best_ff] = 1'b0;
            gate_in[best_ff]  = GATE_OFF;
            wr_en   = 1'b1;
            wr_data = '{EV_RETIRED, 5'(best_ff), bkey_ff, GATE_OFF};
            idx_in  = '0;
         end
         ST_GATE: begin
            if (ped_ff < PEDAL_HOLD && cur_valid && cur_gate == GATE_PEDAL) begin
               gate_in[idx_ff] = GATE_OFF;
               wr_en   = 1'b1;
               wr_data = '{EV_GATE, 5'(idx_ff), key_ff[idx_ff], GATE_OFF};
            end
            idx_in = idx_ff + 1'b1;
         end
         ST_RETIRE_ONE, ST_CLEAR: begin
            if (cur_valid && (state_ff == ST_CLEAR ||
                              32'(cmd_ff.voice_slot) < NUM_VOICES)) begin
               if (cur_dec) begin
                  if (dcnt_ff != '0) dcnt_in = dcnt_ff - 1'b1;
               end else if (held_ff != '0) begin
                  held_in = held_ff - 1'b1;
               end
               valid_in[idx_ff] = 1'b0;
               decay_in[idx_ff] = 1'b0;
               gate_in[idx_ff]  = GATE_OFF;
               wr_en   = 1'b1;
               wr_data = '{EV_RETIRED, 5'(idx_ff), key_ff[idx_ff], GATE_OFF};
            end
            if (state_ff == ST_CLEAR) begin
               idx_in = idx_ff + 1'b1;
               if (last_idx) begin
                  held_in = '0;
                  dcnt_in = '0;
               end
            end
         end
         ST_FINISH: begin
            if (wcnt_ff == '0) begin
               wr_en   = 1'b1;
               wr_data = '{EV_DONE, 5'd0, 7'd0, GATE_OFF};
            end
            rptr_in = '0;
         end
         ST_DRAIN_LD: begin
            if (out_free) begin
               out_in    = rdata_ff;
               oheld_in  = 6'(held_ff);
               odec_in   = 6'(dcnt_ff);
               olast_in  = (WW'(rptr_ff) + 1'b1 == wcnt_ff);
               ovalid_in = 1'b1;
               rptr_in   = rptr_ff + 1'b1;
               if (WW'(rptr_ff) + 1'b1 == wcnt_ff) wcnt_in = '0;
            end
         end
         default: begin
         end
      endcase

      if (wr_en) wcnt_in = wcnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         decay_ff  <= '0;
         gate_ff   <= '{default: GATE_OFF};
         ctr_ff    <= '0;
         ped_ff    <= '0;
         held_ff   <= '0;
         dcnt_ff   <= '0;
         wcnt_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         decay_ff  <= decay_in;
         gate_ff   <= gate_in;
         ctr_ff    <= ctr_in;
         ped_ff    <= ped_in;
         held_ff   <= held_in;
         dcnt_ff   <= dcnt_in;
         wcnt_ff   <= wcnt_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      stamp_ff <= stamp_in;
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      fr_ff    <= fr_in;
      frf_ff   <= frf_in;
      old_ff   <= old_in;
      oldf_ff  <= oldf_in;
      best_ff  <= best_in;
      bestf_ff <= bestf_in;
      bage_ff  <= bage_in;
      bkey_ff  <= bkey_in;
      bdec_ff  <= bdec_in;
      rptr_ff  <= rptr_in;
      out_ff   <= out_in;
      oheld_ff <= oheld_in;
      odec_ff  <= odec_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wcnt_ff[AW-1:0]] <= wr_data;
      end
      rdata_ff <= mem[rptr_ff];
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {3'b000, odec_ff, oheld_ff, out_ff.gate, out_ff.key,
                        out_ff.slot, out_ff.ev};

endmodule

// ----- hw/rtl/polyphonic_voice_allocator_unit.sv -----
// Flow: pedal and unused commands pass through the finish state, a result-buffer read and
// the response register; note-on and clear first walk the voice table, note-off walks it until
// the key is found, finish retires its slot directly, and a window tick scans once per evicted
// voice, then walks the table to release pedal gates; results then drain one at a time.
// Throughput: one command at a time in the sequencer; two more wait in the queue.
// Reset: synchronous; voice table empty, counters and pedal zero, voice_limit 10.
module polyphonic_voice_allocator_unit #(
   parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // func, note_key, pedal_value, voice_slot
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // event_res, slot_out, key_out, gate,
                                    // held_total, decaying_total
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);
   import pva_pkg::*;

   logic [5:0] limit_ff;
   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   pva_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd)
   );

   pva_engine #(.NUM_VOICES(NUM_VOICES)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .voice_limit (limit_ff),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ----- verif/tb_polyphonic_voice_allocator_unit.sv -----
// Self-checking testbench for polyphonic_voice_allocator_unit: directed and random
// note, pedal, tick, finish, clear and unused commands checked against an in-bench voice table.
// Depends on pva_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_polyphonic_voice_allocator_unit;
   import pva_pkg::*;

   localparam int VOICES      = 32;
   localparam int IDLE_LIMIT  = 40000;
   localparam int SETTLE      = 40;
   localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   typedef struct {
      logic [2:0] ev;
      logic [4:0] slot;
      logic [6:0] key;
      logic [1:0] gate;
      logic [5:0] held;
      logic [5:0] decay;
      logic       last;
   } voice_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [5:0]  csr_wdata = '0;

   polyphonic_voice_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // voice table mirror
   logic        v_valid [VOICES];
   logic [6:0]  v_key   [VOICES];
   logic        v_dec   [VOICES];
   logic [1:0]  v_gate  [VOICES];
   logic [15:0] v_stamp [VOICES];
   logic [15:0] stamp_ctr;
   logic [6:0]  pedal_lvl;
   int          held_cnt, decay_cnt;
   logic [5:0]  limit_reg;

   voice_event_type expected_events[$];
   voice_event_type item_events[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void add_event(input logic [2:0] ev, input int slot,
                                     input logic [6:0] key, input logic [1:0] gate);
      voice_event_type e;
      e.ev = ev; e.slot = 5'(slot); e.key = key; e.gate = gate;
      e.held = '0; e.decay = '0; e.last = 1'b0;
      item_events = {item_events, e};
   endfunction

   function automatic logic [15:0] next_stamp();
      logic [15:0] s;
      s = stamp_ctr;
      stamp_ctr = stamp_ctr + 16'd1;
      return s;
   endfunction

   function automatic void retire_voice(input int i);
      if (v_dec[i]) begin
         if (decay_cnt > 0) decay_cnt--;
      end else begin
         if (held_cnt > 0) held_cnt--;
      end
      v_valid[i] = 1'b0;
      v_dec[i] = 1'b0;
      v_gate[i] = GATE_OFF;
      add_event(EV_RETIRED, i, v_key[i], GATE_OFF);
   endfunction

   function automatic int held_slot_of(input logic [6:0] key);
      for (int i = 0; i < VOICES; i++)
         if (v_valid[i] && !v_dec[i] && v_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int choose_victim(input logic want_dec, input logic newest);
      int best;
      logic [15:0] age, best_age;
      best = -1;
      best_age = '0;
      for (int i = 0; i < VOICES; i++) begin
         if (!v_valid[i] || v_dec[i] != want_dec) continue;
         age = stamp_ctr - v_stamp[i];
         if (best < 0 || (newest ? age < best_age : age > best_age)) begin
            best = i;
            best_age = age;
         end
      end
      return best;
   endfunction

   function automatic void predict_voice_events(input logic [2:0] fn, input logic [6:0] key,
                                                input logic [6:0] ped, input logic [4:0] vs);
      int fr, old, i, lim;
      item_events.delete();
      lim = limit_reg;
      case (fn)
         FUNC_NOTE_ON: begin
            fr = -1;
            for (i = 0; i < VOICES; i++)
               if (!v_valid[i] && fr < 0) fr = i;
            if (fr < 0) begin
               add_event(EV_FULL, 0, key, GATE_OFF);
            end else begin
               old = held_slot_of(key);
               if (old >= 0) begin
                  v_dec[old] = 1'b1;
                  v_gate[old] = GATE_OFF;
                  v_stamp[old] = next_stamp();
                  if (held_cnt > 0) held_cnt--;
                  decay_cnt++;
                  add_event(EV_GATE, old, key, GATE_OFF);
               end
               v_valid[fr] = 1'b1;
               v_dec[fr] = 1'b0;
               v_key[fr] = key;
               v_gate[fr] = GATE_ON;
               v_stamp[fr] = next_stamp();
               held_cnt++;
               add_event(EV_ALLOC, fr, key, GATE_ON);
            end
         end
         FUNC_NOTE_OFF: begin
            i = held_slot_of(key);
            if (i >= 0) begin
               v_gate[i] = (pedal_lvl != 0) ? GATE_PEDAL : GATE_OFF;
               add_event(EV_GATE, i, key, v_gate[i]);
            end
         end
         FUNC_PEDAL: pedal_lvl = ped;
         FUNC_TICK: begin
            if (lim > 0 && held_cnt + decay_cnt > lim) begin
               while (decay_cnt > 0 && held_cnt + decay_cnt > lim) begin
                  i = choose_victim(1'b1, 1'b1);
                  if (i < 0) break;
                  retire_voice(i);
               end
               while (held_cnt > lim) begin
                  i = choose_victim(1'b0, 1'b0);
                  if (i < 0) break;
                  retire_voice(i);
               end
            end
            if (pedal_lvl < PEDAL_HOLD)
               for (i = 0; i < VOICES; i++)
                  if (v_valid[i] && v_gate[i] == GATE_PEDAL) begin
                     v_gate[i] = GATE_OFF;
                     add_event(EV_GATE, i, v_key[i], GATE_OFF);
                  end
         end
         FUNC_FINISHED: if (v_valid[vs]) retire_voice(vs);
         FUNC_CLEAR: begin
            for (i = 0; i < VOICES; i++)
               if (v_valid[i]) retire_voice(i);
            held_cnt = 0;
            decay_cnt = 0;
         end
         default: ;
      endcase
      if (item_events.size() == 0) add_event(EV_DONE, 0, 7'd0, GATE_OFF);
      foreach (item_events[k]) begin
         item_events[k].held = 6'(held_cnt);
         item_events[k].decay = 6'(decay_cnt);
         item_events[k].last = (k == item_events.size() - 1);
         expected_events = {expected_events, item_events[k]};
      end
   endfunction

   task automatic send_cmd(input logic [2:0] fn, input logic [6:0] key,
                           input logic [6:0] ped, input logic [4:0] vs);
      int gap;
      req_tdata <= {2'b00, vs, ped, key, fn};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_voice_events(fn, key, ped, vs);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_events.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(input logic [5:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      limit_reg = value;
      csr_we <= 1'b0;
   endtask

   // receiver stall pattern and result check
   int rx_cycle = 0;
   always @(posedge clock) begin
      voice_event_type e;
      rx_cycle++;
      case (rx_cycle[10:9])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (rx_cycle % 3 == 0);
         default: rsp_tready <= $urandom_range(0, 1);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            report("unexpected transaction", rsp_tdata, 0);
         end else begin
            e = expected_events.pop_front();
            if (rsp_tdata[2:0] !== e.ev) report("event", rsp_tdata[2:0], e.ev);
            if (rsp_tdata[7:3] !== e.slot) report("slot", rsp_tdata[7:3], e.slot);
            if (rsp_tdata[14:8] !== e.key) report("key", rsp_tdata[14:8], e.key);
            if (rsp_tdata[16:15] !== e.gate) report("gate", rsp_tdata[16:15], e.gate);
            if (rsp_tdata[22:17] !== e.held) report("held", rsp_tdata[22:17], e.held);
            if (rsp_tdata[28:23] !== e.decay) report("decaying", rsp_tdata[28:23], e.decay);
            if (rsp_tdata[31:29] !== 3'b000) report("padding", rsp_tdata[31:29], 0);
            if (rsp_tlast !== e.last) report("last", rsp_tlast, e.last);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic test_basic_notes();
      send_cmd(FUNC_NOTE_ON, 7'd0, 7'd0, 5'd0);
      send_cmd(FUNC_NOTE_ON, 7'd127, 7'd0, 5'd0);
      send_cmd(FUNC_NOTE_ON, 7'd127, 7'd0, 5'd0);
      send_cmd(FUNC_NOTE_OFF, 7'd0, 7'd0, 5'd0);
      send_cmd(FUNC_NOTE_OFF, 7'd55, 7'd0, 5'd0);
      send_cmd(FUNC_PEDAL, 7'd0, 7'd127, 5'd0);
      send_cmd(FUNC_NOTE_OFF, 7'd127, 7'd0, 5'd0);
      send_cmd(FUNC_TICK, 7'd0, 7'd0, 5'd0);
      send_cmd(FUNC_PEDAL, 7'd0, 7'h3f, 5'd0);
      send_cmd(FUNC_TICK, 7'd0, 7'd0, 5'd0);
      send_cmd(FUNC_FINISHED, 7'd0, 7'd0, 5'd31);
      send_cmd(FUNC_FINISHED, 7'd0, 7'd0, 5'd1);
      send_cmd(FUNC_UNUSED_LO, 7'h55, 7'h2a, 5'h15);
      send_cmd(FUNC_UNUSED_HI, 7'h2a, 7'h55, 5'h0a);
      send_cmd(FUNC_CLEAR, 7'd0, 7'd0, 5'd0);
      send_cmd(FUNC_CLEAR, 7'd0, 7'd0, 5'd0);
      send_cmd(FUNC_TICK, 7'd0, 7'd0, 5'd0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < VOICES; i++) send_cmd(FUNC_NOTE_ON, 7'(i * 3), 7'd0, 5'd0);
      send_cmd(FUNC_NOTE_ON, 7'd3, 7'd0, 5'd0);
      send_cmd(FUNC_NOTE_ON, 7'd100, 7'd0, 5'd0);
      send_cmd(FUNC_TICK, 7'd0, 7'd0, 5'd0);
      send_cmd(FUNC_CLEAR, 7'd0, 7'd0, 5'd0);
   endtask

   task automatic test_random(input int count, input int key_span);
      int sel;
      logic [6:0] key;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         key = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, key_span))
                                           : 7'($urandom_range(0, 127));
         if (sel < 38) send_cmd(FUNC_NOTE_ON, key, 7'($urandom), 5'($urandom));
         else if (sel < 62) send_cmd(FUNC_NOTE_OFF, key, 7'($urandom), 5'($urandom));
         else if (sel < 78) send_cmd(FUNC_TICK, key, 7'($urandom), 5'($urandom));
         else if (sel < 86)
            send_cmd(FUNC_PEDAL, key, 7'($urandom_range(0, 127)), 5'($urandom));
         else if (sel < 95) send_cmd(FUNC_FINISHED, key, 7'($urandom), 5'($urandom));
         else if (sel < 97) send_cmd(FUNC_CLEAR, key, 7'($urandom), 5'($urandom));
         else send_cmd(3'($urandom_range(6, 7)), key, 7'($urandom), 5'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < VOICES; i++) begin
         v_valid[i] = 1'b0; v_key[i] = '0; v_dec[i] = 1'b0;
         v_gate[i] = GATE_OFF; v_stamp[i] = '0;
      end
      stamp_ctr = '0; pedal_lvl = '0; held_cnt = 0; decay_cnt = 0;
      limit_reg = LIMIT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_notes();
      test_full_table();
      write_limit(6'd1);
      test_random(90, 20);
      write_limit(6'd0);
      test_random(90, 40);
      write_limit(6'd32);
      test_random(60, 40);
      write_limit(6'(6'd2 + $urandom_range(0, 12)));
      test_random(90, 15);
      write_limit(6'd10);
      test_random(40, 127);

      drain();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/pva_pkg.sv
hw/rtl/pva_front.sv
hw/rtl/pva_engine.sv
hw/rtl/polyphonic_voice_allocator_unit.sv
verif/tb_polyphonic_voice_allocator_unit.sv
